[rtl/core/spa_pkg.sv]
// Shared constants for the slot pool allocator: command and status codes,
// default pool size. No dependencies.
package spa_pkg;

  localparam int POOL_SIZE_DEF = 16;

  localparam int CMD_W    = 2;
  localparam int SLOT_W   = 4;
  localparam int STATUS_W = 2;

  localparam logic [CMD_W-1:0] CMD_ALLOC       = 2'd0;
  localparam logic [CMD_W-1:0] CMD_RELEASE     = 2'd1;
  localparam logic [CMD_W-1:0] CMD_RELEASE_ALL = 2'd2;

  localparam logic [STATUS_W-1:0] STS_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STS_EMPTY     = 2'd1;
  localparam logic [STATUS_W-1:0] STS_NOT_ALLOC = 2'd2;

endpackage

[rtl/core/spa_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module spa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/core/slot_pool_allocator_core.sv]
// Slot pool allocator: free and allocated doubly linked lists over one pair
// of link RAMs. Depends on spa_pkg and spa_ram.
// Sequence from accept to result beat: allocate steps A1-A3, release R1-R3, release-all with slots
// allocated C1-C2, any other command straight to FIN; at most one write per link RAM per sequencer step.
// Throughput: one command at a time, the next taken the cycle after its result loads.
// Reset: control registers clear, then a sweep over every slot chains the free list; stalled meanwhile.
module slot_pool_allocator_core #(
  parameter int POOL_SIZE = spa_pkg::POOL_SIZE_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cmd_valid,
  output logic                         cmd_stall,
  input  logic [spa_pkg::CMD_W-1:0]    command,
  input  logic [spa_pkg::SLOT_W-1:0]   slot,
  output logic                         rsp_valid,
  input  logic                         rsp_stall,
  output logic [spa_pkg::STATUS_W-1:0] status,
  output logic [spa_pkg::SLOT_W-1:0]   granted_slot,
  output logic                         has_free
);
  import spa_pkg::*;

  localparam int AW = $clog2(POOL_SIZE);
  localparam int LW = $clog2(POOL_SIZE + 1);
  localparam logic [LW-1:0] NIL = LW'(POOL_SIZE);

  typedef logic [LW-1:0] link_t;

  typedef enum logic [10:0] {
    ST_INIT = 11'b000_0000_0001,
    ST_IDLE = 11'b000_0000_0010,
    ST_A1   = 11'b000_0000_0100,
    ST_A2   = 11'b000_0000_1000,
    ST_A3   = 11'b000_0001_0000,
    ST_R1   = 11'b000_0010_0000,
    ST_R2   = 11'b000_0100_0000,
    ST_R3   = 11'b000_1000_0000,
    ST_C1   = 11'b001_0000_0000,
    ST_C2   = 11'b010_0000_0000,
    ST_FIN  = 11'b100_0000_0000
  } state_t;

  function automatic logic is_slot(input link_t l);
    return l < NIL;
  endfunction

  function automatic logic [AW-1:0] addr_of(input link_t l);
    return l[AW-1:0];
  endfunction

  state_t                state, state_next;
  logic [AW-1:0]         init_cnt, init_cnt_next;
  link_t                 free_head, free_head_next;
  link_t                 alloc_head, alloc_head_next;
  link_t                 alloc_tail, alloc_tail_next;
  logic [POOL_SIZE-1:0]  in_use, in_use_next;
  link_t                 cur, cur_next;
  link_t                 lk_p, lk_p_next;
  link_t                 lk_n, lk_n_next;
  logic [STATUS_W-1:0]   res_status, res_status_next;
  logic [SLOT_W-1:0]     res_slot, res_slot_next;
  logic                  rsp_load;

  logic                  nxt_we, prv_we;
  logic [AW-1:0]         nxt_waddr, prv_waddr, nxt_raddr, prv_raddr;
  link_t                 nxt_wdata, prv_wdata, nxt_rdata, prv_rdata;

  logic                  slot_ok;
  logic [AW-1:0]         slot_addr;

  assign slot_ok   = 32'(slot) < 32'(POOL_SIZE);
  assign slot_addr = AW'(slot);
  assign cmd_stall = (state != ST_IDLE);

  spa_ram #(.WIDTH(LW), .DEPTH(POOL_SIZE)) u_next_ram (
    .clk   (clk),
    .we    (nxt_we),
    .waddr (nxt_waddr),
    .wdata (nxt_wdata),
    .raddr (nxt_raddr),
    .rdata (nxt_rdata)
  );

  spa_ram #(.WIDTH(LW), .DEPTH(POOL_SIZE)) u_prev_ram (
    .clk   (clk),
    .we    (prv_we),
    .waddr (prv_waddr),
    .wdata (prv_wdata),
    .raddr (prv_raddr),
    .rdata (prv_rdata)
  );

  always_comb begin
    state_next      = state;
    init_cnt_next   = init_cnt;
    free_head_next  = free_head;
    alloc_head_next = alloc_head;
    alloc_tail_next = alloc_tail;
    in_use_next     = in_use;
    cur_next        = cur;
    lk_p_next       = lk_p;
    lk_n_next       = lk_n;
    res_status_next = res_status;
    res_slot_next   = res_slot;
    rsp_load        = 1'b0;
    nxt_we          = 1'b0;
    nxt_waddr       = addr_of(cur);
    nxt_wdata       = NIL;
    nxt_raddr       = addr_of(cur);
    prv_we          = 1'b0;
    prv_waddr       = addr_of(cur);
    prv_wdata       = NIL;
    prv_raddr       = addr_of(cur);

    case (state)
      ST_INIT: begin
        nxt_we    = 1'b1;
        nxt_waddr = init_cnt;
        nxt_wdata = LW'(init_cnt) + LW'(1);
        prv_we    = 1'b1;
        prv_waddr = init_cnt;
        prv_wdata = (init_cnt == '0) ? NIL : LW'(init_cnt) - LW'(1);
        if (init_cnt == AW'(POOL_SIZE - 1)) begin
          state_next = ST_IDLE;
        end else begin
          init_cnt_next = init_cnt + AW'(1);
        end
      end
      ST_IDLE: begin
        if (cmd_valid) begin
          res_status_next = STS_OK;
          res_slot_next   = '0;
          state_next      = ST_FIN;
          case (command)
            CMD_ALLOC: begin
              if (is_slot(free_head)) begin
                nxt_raddr     = addr_of(free_head);
                cur_next      = free_head;
                res_slot_next = SLOT_W'(free_head);
                state_next    = ST_A1;
              end else begin
                res_status_next = STS_EMPTY;
              end
            end
            CMD_RELEASE: begin
              if (slot_ok && in_use[slot_addr]) begin
                nxt_raddr  = slot_addr;
                prv_raddr  = slot_addr;
                cur_next   = LW'(slot);
                state_next = ST_R1;
              end else begin
                res_status_next = STS_NOT_ALLOC;
              end
            end
            CMD_RELEASE_ALL: begin
              if (is_slot(alloc_head)) begin
                state_next = ST_C1;
              end
            end
            default: begin
              state_next = ST_FIN;
            end
          endcase
        end
      end
      // allocate: pop free head, push it on the allocated head
      ST_A1: begin
        lk_n_next      = nxt_rdata;
        free_head_next = nxt_rdata;
        prv_we         = 1'b1;
        prv_waddr      = addr_of(cur);
        prv_wdata      = NIL;
        nxt_we         = 1'b1;
        nxt_waddr      = addr_of(cur);
        nxt_wdata      = alloc_head;
        state_next     = ST_A2;
      end
      ST_A2: begin
        if (is_slot(lk_n)) begin
          prv_we    = 1'b1;
          prv_waddr = addr_of(lk_n);
          prv_wdata = NIL;
        end
        state_next = ST_A3;
      end
      ST_A3: begin
        if (is_slot(alloc_head)) begin
          prv_we    = 1'b1;
          prv_waddr = addr_of(alloc_head);
          prv_wdata = cur;
        end else begin
          alloc_tail_next = cur;
        end
        alloc_head_next           = cur;
        in_use_next[addr_of(cur)] = 1'b1;
        state_next                = ST_FIN;
      end
      // release: unlink from the allocated list, push on the free head
      ST_R1: begin
        lk_p_next = prv_rdata;
        lk_n_next = nxt_rdata;
        if (is_slot(prv_rdata)) begin
          nxt_we    = 1'b1;
          nxt_waddr = addr_of(prv_rdata);
          nxt_wdata = nxt_rdata;
        end
        if (is_slot(nxt_rdata)) begin
          prv_we    = 1'b1;
          prv_waddr = addr_of(nxt_rdata);
          prv_wdata = prv_rdata;
        end
        state_next = ST_R2;
      end
      ST_R2: begin
        nxt_we    = 1'b1;
        nxt_waddr = addr_of(cur);
        nxt_wdata = free_head;
        if (is_slot(free_head)) begin
          prv_we    = 1'b1;
          prv_waddr = addr_of(free_head);
          prv_wdata = cur;
        end
        state_next = ST_R3;
      end
      ST_R3: begin
        prv_we    = 1'b1;
        prv_waddr = addr_of(cur);
        prv_wdata = NIL;
        if (alloc_head == cur) begin
          alloc_head_next = lk_n;
        end
        if (alloc_tail == cur) begin
          alloc_tail_next = lk_p;
        end
        free_head_next            = cur;
        in_use_next[addr_of(cur)] = 1'b0;
        state_next                = ST_FIN;
      end
      // release-all: the tracked tail links onto the old free head
      ST_C1: begin
        nxt_we    = 1'b1;
        nxt_waddr = addr_of(alloc_tail);
        nxt_wdata = free_head;
        if (is_slot(free_head)) begin
          prv_we    = 1'b1;
          prv_waddr = addr_of(free_head);
          prv_wdata = alloc_tail;
        end
        state_next = ST_C2;
      end
      ST_C2: begin
        prv_we          = 1'b1;
        prv_waddr       = addr_of(alloc_head);
        prv_wdata       = NIL;
        free_head_next  = alloc_head;
        alloc_head_next = NIL;
        alloc_tail_next = NIL;
        in_use_next     = '0;
        state_next      = ST_FIN;
      end
      ST_FIN: begin
        if (!rsp_valid || !rsp_stall) begin
          rsp_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_INIT;
      init_cnt   <= '0;
      free_head  <= '0;
      alloc_head <= NIL;
      alloc_tail <= NIL;
      in_use     <= '0;
      rsp_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      init_cnt   <= init_cnt_next;
      free_head  <= free_head_next;
      alloc_head <= alloc_head_next;
      alloc_tail <= alloc_tail_next;
      in_use     <= in_use_next;
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cur        <= cur_next;
    lk_p       <= lk_p_next;
    lk_n       <= lk_n_next;
    res_status <= res_status_next;
    res_slot   <= res_slot_next;
    if (rsp_load) begin
      status       <= res_status;
      granted_slot <= res_slot;
      has_free     <= is_slot(free_head);
    end
  end

endmodule
